// File: src/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the button press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  localparam int unsigned TIME_BITS_DEFAULT = 32;
  localparam int unsigned LPM_BITS          = 16;
  localparam logic [LPM_BITS-1:0] LONG_PRESS_RESET = 16'd1000;
  localparam int unsigned PRESS_TIME_BITS   = 32;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_PRESS   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_READ    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    EV_PRESSED        = 3'd0,
    EV_RELEASED       = 3'd1,
    EV_LONG_PRESSED   = 3'd2,
    EV_SHORT_PRESSED  = 3'd3,
    EV_SHORT_RELEASED = 3'd4,
    EV_LONG_RELEASED  = 3'd5
  } event_t;

  typedef struct packed {
    action_t action;
    event_t  event_sel;
  } cmd_t;

  typedef struct packed {
    logic                       event_fired;
    logic                       is_pressed;
    logic                       is_long_pressed;
    logic                       state_changed;
    logic [PRESS_TIME_BITS-1:0] press_time;
  } res_t;

  typedef struct packed {
    logic held;
    logic change_pending;
    logic long_detected;
    logic long_reported;
    logic short_reported;
    logic release_pending;
    logic release_reported;
    logic short_release_reported;
    logic long_release_reported;
  } flags_t;

endpackage

`default_nettype wire

// File: src/button_press_classifier_unit.sv
// ----------------------------------------------------------------------------
// button_press_classifier_unit
// Short and long press classifier for debounced button events.
// ----------------------------------------------------------------------------
// Command channel (cmd_valid, cmd_stall, cmd): one item per transfer, either
// a 1 ms tick, a press, a release or a read-and-clear event query.
// Result channel (res_valid, res_stall, res): exactly one result per command,
// in order, giving the query outcome and the state after the command.
// Configuration: cfg_we writes cfg_data into the long press threshold (ms);
// write only while no command is in flight.
// The result is registered in the output register, or in the skid entry.
// Throughput: one command per clock while cmd_stall is low; the state update
// is a single pass of flag logic plus one subtract and compare in the engine.
// Stalls: the result register is backed by a single skid entry; cmd_stall
// rises only once that entry is occupied, and falls when the receiver takes
// the waiting result.
// Reset (rst, synchronous): clears the time counter, press stamp and all
// flags, empties the result path and restores a 1000 ms threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_classifier_unit #(
  parameter int unsigned TIME_BITS = bpc_pkg::TIME_BITS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [bpc_pkg::LPM_BITS-1:0]  cfg_data,
  input  wire logic                          cmd_valid,
  output logic                               cmd_stall,
  input  wire bpc_pkg::cmd_t                 cmd,
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output bpc_pkg::res_t                      res
);
  import bpc_pkg::*;

  logic accept;
  res_t result;
  logic full;

  assign cmd_stall = full;
  assign accept    = cmd_valid && !full;

  bpc_engine #(
    .TIME_BITS (TIME_BITS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .accept   (accept),
    .cmd      (cmd),
    .result   (result)
  );

  bpc_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .full      (full),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

`default_nettype wire

// File: src/bpc_engine.sv
// ----------------------------------------------------------------------------
// bpc_engine
// Press state, time counter and event flags; updates on each transfer and
// forms the result from the updated state.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_engine #(
  parameter int unsigned TIME_BITS = bpc_pkg::TIME_BITS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [bpc_pkg::LPM_BITS-1:0]  cfg_data,
  input  wire logic                          accept,
  input  wire bpc_pkg::cmd_t                 cmd,
  output bpc_pkg::res_t                      result
);
  import bpc_pkg::*;

  logic [LPM_BITS-1:0]  long_press_ms;
  logic [TIME_BITS-1:0] time_now, time_now_next;
  logic [TIME_BITS-1:0] press_stamp, press_stamp_next;
  logic [TIME_BITS-1:0] held_time;
  flags_t               flags, flags_next;
  logic                 fired;

  assign held_time = time_now_next - press_stamp;

  always_comb begin
    time_now_next    = time_now;
    press_stamp_next = press_stamp;
    flags_next       = flags;
    fired            = 1'b0;
    unique case (cmd.action)
      ACT_TICK: begin
        time_now_next = time_now + 1'b1;
        if (flags.held && !flags.long_detected &&
            held_time >= TIME_BITS'(long_press_ms)) begin
          flags_next.long_detected = 1'b1;
          flags_next.long_reported = 1'b0;
        end
      end
      ACT_PRESS: begin
        if (!flags.held) begin
          press_stamp_next = time_now;
          flags_next       = '0;
          flags_next.held  = 1'b1;
          flags_next.change_pending = 1'b1;
        end
      end
      ACT_RELEASE: begin
        if (flags.held) begin
          flags_next.held             = 1'b0;
          flags_next.change_pending   = 1'b1;
          flags_next.release_pending  = 1'b1;
          flags_next.release_reported = 1'b0;
        end
      end
      ACT_READ: begin
        case (cmd.event_sel)
          EV_PRESSED: begin
            if (flags.change_pending && flags.held) begin
              flags_next.change_pending = 1'b0;
              fired = 1'b1;
            end
          end
          EV_RELEASED: begin
            if (flags.change_pending && !flags.held) begin
              flags_next.change_pending = 1'b0;
              fired = 1'b1;
            end
          end
          EV_LONG_PRESSED: begin
            if (flags.long_detected && !flags.long_reported) begin
              flags_next.long_reported  = 1'b1;
              flags_next.short_reported = 1'b1;
              fired = 1'b1;
            end
          end
          EV_SHORT_PRESSED: begin
            if (flags.release_pending && !flags.release_reported &&
                !flags.short_reported) begin
              flags_next.release_reported = 1'b1;
              flags_next.short_reported   = 1'b1;
              flags_next.release_pending  = 1'b0;
              flags_next.long_detected    = 1'b0;
              flags_next.long_reported    = 1'b0;
              fired = 1'b1;
            end
          end
          EV_SHORT_RELEASED: begin
            if (flags.release_pending && !flags.long_detected &&
                !flags.short_release_reported) begin
              flags_next.short_release_reported = 1'b1;
              flags_next.release_pending        = 1'b0;
              flags_next.release_reported       = 1'b1;
              flags_next.short_reported         = 1'b1;
              flags_next.long_reported          = 1'b0;
              fired = 1'b1;
            end
          end
          EV_LONG_RELEASED: begin
            if (flags.release_pending && flags.long_detected &&
                !flags.long_release_reported) begin
              flags_next.long_release_reported = 1'b1;
              flags_next.release_pending       = 1'b0;
              flags_next.release_reported      = 1'b1;
              flags_next.long_detected         = 1'b0;
              flags_next.long_reported         = 1'b0;
              flags_next.short_reported        = 1'b0;
              fired = 1'b1;
            end
          end
          default: fired = 1'b0; // unused selectors leave everything alone
        endcase
      end
      default: fired = 1'b0;
    endcase
  end

  always_comb begin
    result.event_fired     = fired;
    result.is_pressed      = flags_next.held;
    result.is_long_pressed = flags_next.long_detected;
    result.state_changed   = flags_next.change_pending;
    result.press_time      = PRESS_TIME_BITS'(press_stamp_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms <= LONG_PRESS_RESET;
      time_now      <= '0;
      press_stamp   <= '0;
      flags         <= '0;
    end else begin
      if (cfg_we) begin
        long_press_ms <= cfg_data;
      end
      if (accept) begin
        time_now    <= time_now_next;
        press_stamp <= press_stamp_next;
        flags       <= flags_next;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_tick_advances: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.action == ACT_TICK |=> time_now == TIME_BITS'($past(time_now) + 1'b1))
    else $error("time counter did not advance on tick");

  a_press_stamps: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.action == ACT_PRESS && !flags.held
    |=> flags.held && flags.change_pending && press_stamp == $past(time_now))
    else $error("new press not stamped");
`endif

endmodule

`default_nettype wire

// File: src/bpc_out_skid.sv
// ----------------------------------------------------------------------------
// bpc_out_skid
// Result register with one skid entry, so a new transfer is taken while the
// receiver stalls the current result.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_out_skid (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire bpc_pkg::res_t  push_data,
  output logic                full,
  output logic                res_valid,
  input  wire logic           res_stall,
  output bpc_pkg::res_t       res
);
  import bpc_pkg::*;

  logic skid_valid;
  res_t skid;
  logic load;

  assign load = !res_valid || !res_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= skid_valid ? skid : push_data;
    end else if (push) begin
      skid <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid holds data with empty output register");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && skid_valid))
    else $error("transfer accepted into full skid");
`endif

endmodule

`default_nettype wire

// File: tb/tb_button_press_classifier_unit.sv
// ----------------------------------------------------------------------------
// tb_button_press_classifier_unit
// Self-checking bench for the short/long button press classifier. Ticks,
// presses, releases and event reads are sent over the command channel. A
// behavioural model predicts the status of every command, and each result
// transfer is checked against it in order. Both channels idle at random, and
// the long press threshold is swept between runs, its extremes included.
// ----------------------------------------------------------------------------
module tb_button_press_classifier_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned MAX_REPORTS = 10;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic [LPM_BITS-1:0] cfg_data  = '0;
  logic                cmd_valid = 1'b0;
  logic                cmd_stall;
  cmd_t                cmd       = '{action: ACT_TICK, event_sel: EV_PRESSED};
  logic                res_valid;
  logic                res_stall = 1'b0;
  res_t                res;

  // model state
  logic [31:0]         now_ms    = '0;
  logic [31:0]         stamp_ms  = '0;
  logic [LPM_BITS-1:0] thr_ms    = LONG_PRESS_RESET;
  logic held_q = 1'b0, chg_pend = 1'b0, long_det = 1'b0, long_rep = 1'b0;
  logic short_rep = 1'b0, rel_pend = 1'b0, rel_rep = 1'b0;
  logic srel_rep = 1'b0, lrel_rep = 1'b0;

  res_t expected_status[$];
  bit   gaps_on     = 1'b1;
  int   n_items     = 0;
  int   n_bad       = 0;
  int   stall_left  = 0;
  int   cycle_count = 0;

  button_press_classifier_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** button_press_classifier_unit: FAILED **");
      $finish;
    end
  end

  // Advance the model by one command and return the status it should report.
  function automatic res_t classify_step(action_t act, logic [2:0] sel);
    res_t r;
    logic fired;
    fired = 1'b0;
    case (act)
      ACT_TICK: begin
        now_ms = now_ms + 32'd1;
        if (held_q && !long_det && (now_ms - stamp_ms) >= {16'd0, thr_ms}) begin
          long_det = 1'b1;
          long_rep = 1'b0;
        end
      end
      ACT_PRESS: if (!held_q) begin
        held_q    = 1'b1;
        chg_pend  = 1'b1;
        stamp_ms  = now_ms;
        long_det  = 1'b0;
        long_rep  = 1'b0;
        short_rep = 1'b0;
        rel_pend  = 1'b0;
        rel_rep   = 1'b0;
        srel_rep  = 1'b0;
        lrel_rep  = 1'b0;
      end
      ACT_RELEASE: if (held_q) begin
        held_q   = 1'b0;
        chg_pend = 1'b1;
        rel_pend = 1'b1;
        rel_rep  = 1'b0;
      end
      default: begin
        case (sel)
          EV_PRESSED: if (chg_pend && held_q) begin
            chg_pend = 1'b0;
            fired    = 1'b1;
          end
          EV_RELEASED: if (chg_pend && !held_q) begin
            chg_pend = 1'b0;
            fired    = 1'b1;
          end
          EV_LONG_PRESSED: if (long_det && !long_rep) begin
            long_rep  = 1'b1;
            short_rep = 1'b1;
            fired     = 1'b1;
          end
          EV_SHORT_PRESSED: if (rel_pend && !rel_rep && !short_rep) begin
            rel_rep   = 1'b1;
            short_rep = 1'b1;
            rel_pend  = 1'b0;
            long_det  = 1'b0;
            long_rep  = 1'b0;
            fired     = 1'b1;
          end
          EV_SHORT_RELEASED: if (rel_pend && !long_det && !srel_rep) begin
            srel_rep  = 1'b1;
            rel_pend  = 1'b0;
            rel_rep   = 1'b1;
            short_rep = 1'b1;
            long_rep  = 1'b0;
            fired     = 1'b1;
          end
          EV_LONG_RELEASED: if (rel_pend && long_det && !lrel_rep) begin
            lrel_rep  = 1'b1;
            rel_pend  = 1'b0;
            rel_rep   = 1'b1;
            long_det  = 1'b0;
            long_rep  = 1'b0;
            short_rep = 1'b0;
            fired     = 1'b1;
          end
          default: ;  // unused selector: no effect
        endcase
      end
    endcase
    r.event_fired     = fired;
    r.is_pressed      = held_q;
    r.is_long_pressed = long_det;
    r.state_changed   = chg_pend;
    r.press_time      = stamp_ms;
    return r;
  endfunction

  // Sends one command; returns at the edge of its transfer with valid left high.
  task automatic push_button_cmd(input action_t act, input logic [2:0] sel);
    int gap;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= '{action: act, event_sel: event_t'(sel)};
    do @(posedge clk); while (cmd_stall);
    if (!((act == ACT_PRESS && held_q) || (act == ACT_RELEASE && !held_q) ||
          (act == ACT_READ && sel > 3'd5)))
      n_items++;
    expected_status.push_back(classify_step(act, sel));
  endtask

  task automatic drain_results();
    cmd_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [LPM_BITS-1:0] ms);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= ms;
    @(posedge clk);
    cfg_we   <= 1'b0;
    thr_ms    = ms;
  endtask

  task automatic tick_run(input int n);
    repeat (n) push_button_cmd(ACT_TICK, 3'($urandom_range(0, 7)));
  endtask

  // receiver: after each result transfer, may stall at random before taking the next
  always @(posedge clk) begin
    if (rst) begin
      res_stall  <= 1'b0;
      stall_left  = 0;
    end else if (res_valid && !res_stall) begin
      stall_left  = gaps_on ? $urandom_range(0, 7) : 0;
      res_stall  <= (stall_left != 0);
    end else if (stall_left != 0) begin
      stall_left--;
      res_stall  <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    res_t exp_r;
    if (!rst && res_valid && !res_stall) begin
      if (expected_status.size() == 0) begin
        n_bad++;
        if (n_bad <= MAX_REPORTS)
          $display("unexpected result: fired=%0b pressed=%0b long=%0b chg=%0b stamp=%0h",
                   res.event_fired, res.is_pressed, res.is_long_pressed,
                   res.state_changed, res.press_time);
      end else begin
        exp_r = expected_status.pop_front();
        if (res.event_fired !== exp_r.event_fired || res.is_pressed !== exp_r.is_pressed ||
            res.is_long_pressed !== exp_r.is_long_pressed ||
            res.state_changed !== exp_r.state_changed ||
            res.press_time !== exp_r.press_time) begin
          n_bad++;
          if (n_bad <= MAX_REPORTS) begin
            $display("status mismatch exp: fired=%0b pressed=%0b long=%0b chg=%0b stamp=%0h",
                     exp_r.event_fired, exp_r.is_pressed, exp_r.is_long_pressed,
                     exp_r.state_changed, exp_r.press_time);
            $display("                got: fired=%0b pressed=%0b long=%0b chg=%0b stamp=%0h",
                     res.event_fired, res.is_pressed, res.is_long_pressed,
                     res.state_changed, res.press_time);
          end
        end
      end
    end
  end

  // nothing pending after reset: every query, unused selectors too, reports 0
  task automatic test_idle_reads();
    for (int s = 0; s < 8; s++) push_button_cmd(ACT_READ, 3'(s));
    push_button_cmd(ACT_RELEASE, 3'd7);
    push_button_cmd(ACT_TICK, 3'd0);
  endtask

  // threshold out of reset is 1000 ms: a short hold is not long
  task automatic test_default_threshold();
    push_button_cmd(ACT_PRESS, 3'd0);
    tick_run(24);
    push_button_cmd(ACT_READ, EV_LONG_PRESSED);
    push_button_cmd(ACT_TICK, 3'd0);
    push_button_cmd(ACT_READ, EV_LONG_PRESSED);
    push_button_cmd(ACT_RELEASE, 3'd0);
    push_button_cmd(ACT_READ, EV_LONG_RELEASED);
    push_button_cmd(ACT_READ, EV_SHORT_RELEASED);
  endtask

  task automatic test_event_queries();
    write_threshold(16'd3);
    // short press, with repeated press and release ignored
    push_button_cmd(ACT_PRESS, 3'd0);
    push_button_cmd(ACT_PRESS, 3'd7);
    push_button_cmd(ACT_READ, EV_PRESSED);
    push_button_cmd(ACT_READ, EV_PRESSED);
    tick_run(2);
    push_button_cmd(ACT_READ, EV_SHORT_PRESSED);
    push_button_cmd(ACT_RELEASE, 3'd0);
    push_button_cmd(ACT_RELEASE, 3'd0);
    push_button_cmd(ACT_READ, EV_RELEASED);
    push_button_cmd(ACT_READ, EV_SHORT_PRESSED);
    push_button_cmd(ACT_READ, EV_SHORT_RELEASED);
    // long press
    push_button_cmd(ACT_PRESS, 3'd0);
    tick_run(3);
    push_button_cmd(ACT_READ, EV_LONG_PRESSED);
    push_button_cmd(ACT_READ, EV_LONG_PRESSED);
    push_button_cmd(ACT_RELEASE, 3'd0);
    push_button_cmd(ACT_READ, EV_SHORT_RELEASED);
    push_button_cmd(ACT_READ, EV_LONG_RELEASED);
    // short release straight away
    push_button_cmd(ACT_PRESS, 3'd0);
    push_button_cmd(ACT_RELEASE, 3'd0);
    push_button_cmd(ACT_READ, EV_SHORT_RELEASED);
    push_button_cmd(ACT_READ, 3'd6);
    push_button_cmd(ACT_READ, 3'd7);
  endtask

  task automatic test_threshold_extremes();
    write_threshold(16'd0);
    push_button_cmd(ACT_PRESS, 3'd0);
    push_button_cmd(ACT_TICK, 3'd0);
    push_button_cmd(ACT_READ, EV_LONG_PRESSED);
    push_button_cmd(ACT_RELEASE, 3'd0);
    push_button_cmd(ACT_READ, EV_LONG_RELEASED);
    // full-scale threshold: a back-to-back hold stays short
    write_threshold(16'hFFFF);
    gaps_on = 1'b0;
    push_button_cmd(ACT_PRESS, 3'd0);
    tick_run(30);
    push_button_cmd(ACT_READ, EV_LONG_PRESSED);
    push_button_cmd(ACT_TICK, 3'd0);
    push_button_cmd(ACT_READ, EV_LONG_PRESSED);
    push_button_cmd(ACT_RELEASE, 3'd0);
    push_button_cmd(ACT_READ, EV_LONG_RELEASED);
    push_button_cmd(ACT_READ, EV_SHORT_RELEASED);
    gaps_on = 1'b1;
  endtask

  // mostly whole press/hold/release cycles with random reads, some noise
  task automatic test_random_phase(input logic [LPM_BITS-1:0] ms, input bit idle_on,
                                   input int n_target);
    int start;
    int span;
    int hold;
    write_threshold(ms);
    gaps_on = idle_on;
    start   = n_items;
    span    = (ms > 20) ? 40 : 2 * ms + 3;
    while (n_items - start < n_target) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4))
          push_button_cmd(action_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
      end else begin
        push_button_cmd(ACT_PRESS, 3'($urandom_range(0, 7)));
        hold = $urandom_range(0, span);
        for (int i = 0; i < hold; i++) begin
          if ($urandom_range(0, 3) == 0)
            push_button_cmd(ACT_READ, 3'($urandom_range(0, 5)));
          else
            push_button_cmd(ACT_TICK, 3'($urandom_range(0, 7)));
        end
        push_button_cmd(ACT_RELEASE, 3'($urandom_range(0, 7)));
        repeat ($urandom_range(1, 4))
          push_button_cmd(ACT_READ, 3'($urandom_range(0, 7)));
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_idle_reads();
    test_default_threshold();
    test_event_queries();
    test_threshold_extremes();
    test_random_phase(16'd1, 1'b1, 100);
    test_random_phase(16'd5, 1'b1, 100);
    test_random_phase(16'd0, 1'b0, 100);
    test_random_phase(16'd12, 1'b1, 100);
    test_random_phase(16'($urandom_range(0, 65535)), 1'b1, 100);
    test_random_phase(16'd3, 1'b0, 100);
    drain_results();
    if (n_bad == 0)
      $display("** button_press_classifier_unit: PASSED **");
    else
      $display("** button_press_classifier_unit: FAILED **");
    $finish;
  end

endmodule

// File: filelist.f
src/bpc_pkg.sv
src/bpc_engine.sv
src/bpc_out_skid.sv
src/button_press_classifier_unit.sv
tb/tb_button_press_classifier_unit.sv
